@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker of the deadline timer queue.
// Depends on nothing; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/dtq_pkg.sv @@
// Shared constants, codes and item types of the deadline timer queue.
// Depends on nothing; used by every module of the block but dtq_ram.
package dtq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int CMDQ_DEPTH     = 2;
  localparam int RESQ_DEPTH     = 2;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_FIRE   = 2'd3;

  localparam logic [2:0] KIND_EXPIRED = 3'd0;
  localparam logic [2:0] KIND_SUMMARY = 3'd1;
  localparam logic [2:0] KIND_SET     = 3'd2;
  localparam logic [2:0] KIND_REMOVE  = 3'd3;
  localparam logic [2:0] KIND_FIRE    = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         timer_id;
    logic signed [31:0] amount;
    logic               id_ok;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         timer_id_res;
    logic signed [31:0] remaining;
    logic               flag;
    logic               last;
  } res_item_t;

  typedef struct packed {
    logic      avail;
    cmd_item_t item;
  } cq_out_t;

  typedef struct packed {
    logic      push;
    res_item_t item;
  } res_push_t;

endpackage

@@ sv/deadline_timer_queue_unit.sv @@
// Top level of the deadline timer queue: front end, back end, result queue.
// Depends on dtq_pkg, dtq_front, dtq_back, dtq_res_fifo and dtq_ram.
//
//   Channel   Ports                       Transfer when
//   input     in_push/in_full + fields    in_push && !in_full
//   result    out_pop/out_empty + fields  out_pop && !out_empty
//
// Set, remove and fire pass through the command queue; the back end takes
// each in its idle state and writes its result into the result queue.
// A tick is also taken in the idle state; then every result, one per
// expired timer and a final summary, comes from one full scan of the
// slot RAM, whose single registered read port delivers one slot per
// cycle.
// Reset is synchronous and clears the clock, the stamp counter, the armed
// bits and both queues; the slot RAM needs no clearing.
// A full result queue stalls the back end; a full command queue raises
// in_full. Each side stalls without losing a transfer.
module deadline_timer_queue_unit #(
  parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_timer_id,
  input  logic signed [31:0] in_amount,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [2:0]         out_kind,
  output logic [3:0]         out_timer_id_res,
  output logic signed [31:0] out_remaining,
  output logic               out_flag,
  output logic               out_last
);

  // Commands wait in the front queue until the back end is free.
  dtq_pkg::cq_out_t   cq;
  logic               cq_pop;
  dtq_pkg::res_push_t res;
  logic               res_full;
  dtq_pkg::res_item_t head;

  dtq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_cmd      (in_cmd),
    .in_timer_id (in_timer_id),
    .in_amount   (in_amount),
    .cq_o        (cq),
    .cq_pop      (cq_pop)
  );

  // The back end holds all timer state and writes one result per cycle
  // at most into the result queue.
  dtq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_i     (cq),
    .cq_pop   (cq_pop),
    .res_full (res_full),
    .res_o    (res)
  );

  dtq_res_fifo u_res (
    .clk   (clk),
    .rst_n (rst_n),
    .res_i (res),
    .full  (res_full),
    .empty (out_empty),
    .pop   (out_pop),
    .head  (head)
  );

  assign out_kind         = head.kind;
  assign out_timer_id_res = head.timer_id_res;
  assign out_remaining    = head.remaining;
  assign out_flag         = head.flag;
  assign out_last         = head.last;

endmodule

@@ sv/dtq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dtq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dtq_front.sv @@
// Front end: accepts commands, checks the slot number and queues them.
// Depends on dtq_pkg.
module dtq_front #(
  parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_timer_id,
  input  logic signed [31:0] in_amount,
  output dtq_pkg::cq_out_t   cq_o,
  input  logic               cq_pop
);

  localparam int DEPTH = dtq_pkg::CMDQ_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0] NT = 9'(NUM_TIMERS);

  dtq_pkg::cmd_item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          accept, pop_ok;
  dtq_pkg::cmd_item_t item;

  always_comb begin
    item.cmd      = in_cmd;
    item.timer_id = in_timer_id;
    item.amount   = in_amount;
    item.id_ok    = {5'd0, in_timer_id} < NT;
  end

  assign in_full    = cnt_r == (AW+1)'(DEPTH);
  assign accept     = in_push && !in_full;
  assign pop_ok     = cq_pop && (cnt_r != '0);
  assign cq_o.avail = cnt_r != '0;
  assign cq_o.item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (accept && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!accept && pop_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

@@ sv/dtq_back.sv @@
// Back end: holds the timer state and carries out commands; a tick scans
// the slot RAM once per expired timer and once more. Depends on dtq_pkg and dtq_ram.
module dtq_back #(
  parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dtq_pkg::cq_out_t    cq_i,
  output logic                cq_pop,
  input  logic                res_full,
  output dtq_pkg::res_push_t  res_o
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE} state_t;

  state_t state_r, state_nxt;
  logic [31:0] clock_r, clock_nxt, stamp_r, stamp_nxt;
  logic [NUM_TIMERS-1:0] armed_r, armed_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic due_found_r, due_found_nxt, any_found_r, any_found_nxt;
  logic [IW-1:0] due_idx_r, due_idx_nxt;
  logic signed [31:0] due_diff_r, due_diff_nxt, any_diff_r, any_diff_nxt;
  logic [31:0] due_stamp_r, due_stamp_nxt, any_stamp_r, any_stamp_nxt;

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr, proc_idx, cmd_idx;
  logic [63:0] ram_wdata, ram_rdata;
  logic signed [31:0] diff;
  logic [31:0] cand_stamp;
  logic ahead_due, ahead_any;

  dtq_ram #(.WIDTH(64), .DEPTH(NUM_TIMERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd_idx    = IW'(cq_i.item.timer_id);
  assign proc_idx   = IW'(cnt_r - 1'b1);
  assign diff       = signed'(ram_rdata[63:32] - clock_r);
  assign cand_stamp = ram_rdata[31:0];
  assign ahead_due  = !due_found_r || (diff < due_diff_r) ||
                      ((diff == due_diff_r) && (cand_stamp < due_stamp_r));
  assign ahead_any  = !any_found_r || (diff < any_diff_r) ||
                      ((diff == any_diff_r) && (cand_stamp < any_stamp_r));

  always_comb begin
    state_nxt     = state_r;
    clock_nxt     = clock_r;
    stamp_nxt     = stamp_r;
    armed_nxt     = armed_r;
    cnt_nxt       = cnt_r;
    due_found_nxt = due_found_r;
    due_idx_nxt   = due_idx_r;
    due_diff_nxt  = due_diff_r;
    due_stamp_nxt = due_stamp_r;
    any_found_nxt = any_found_r;
    any_diff_nxt  = any_diff_r;
    any_stamp_nxt = any_stamp_r;
    cq_pop        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cmd_idx;
    ram_wdata     = {clock_r + $unsigned(cq_i.item.amount), stamp_r};
    ram_raddr     = IW'(cnt_r);
    res_o         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cq_i.avail && !res_full) begin
          cq_pop = 1'b1;
          res_o.item.timer_id_res = cq_i.item.timer_id;
          res_o.item.last         = 1'b1;
          case (cq_i.item.cmd)
            dtq_pkg::CMD_SET: begin
              res_o.push      = 1'b1;
              res_o.item.kind = dtq_pkg::KIND_SET;
              if (cq_i.item.id_ok) begin
                ram_we             = 1'b1;
                armed_nxt[cmd_idx] = 1'b1;
                stamp_nxt          = stamp_r + 32'd1;
              end
            end
            dtq_pkg::CMD_REMOVE, dtq_pkg::CMD_FIRE: begin
              res_o.push      = 1'b1;
              res_o.item.kind = (cq_i.item.cmd == dtq_pkg::CMD_REMOVE) ?
                                dtq_pkg::KIND_REMOVE : dtq_pkg::KIND_FIRE;
              res_o.item.flag = cq_i.item.id_ok && armed_r[cmd_idx];
              if (cq_i.item.id_ok) begin
                armed_nxt[cmd_idx] = 1'b0;
              end
            end
            default: begin
              clock_nxt     = clock_r + $unsigned(cq_i.item.amount);
              state_nxt     = ST_SCAN;
              cnt_nxt       = '0;
              due_found_nxt = 1'b0;
              any_found_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if ((cnt_r != '0) && armed_r[proc_idx]) begin
          if (ahead_any) begin
            any_found_nxt = 1'b1;
            any_diff_nxt  = diff;
            any_stamp_nxt = cand_stamp;
          end
          if ((diff <= 0) && ahead_due) begin
            due_found_nxt = 1'b1;
            due_idx_nxt   = proc_idx;
            due_diff_nxt  = diff;
            due_stamp_nxt = cand_stamp;
          end
        end
        if (cnt_r == CW'(NUM_TIMERS)) begin
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!res_full) begin
          res_o.push = 1'b1;
          if (due_found_r) begin
            res_o.item.kind         = dtq_pkg::KIND_EXPIRED;
            res_o.item.timer_id_res = 4'(due_idx_r);
            armed_nxt[due_idx_r]    = 1'b0;
            state_nxt               = ST_SCAN;
            cnt_nxt                 = '0;
            due_found_nxt           = 1'b0;
            any_found_nxt           = 1'b0;
          end else begin
            res_o.item.kind      = dtq_pkg::KIND_SUMMARY;
            res_o.item.remaining = any_found_r ? any_diff_r : 32'sd0;
            res_o.item.flag      = !any_found_r;
            res_o.item.last      = 1'b1;
            state_nxt            = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clock_r     <= '0;
      stamp_r     <= '0;
      armed_r     <= '0;
      cnt_r       <= '0;
      due_found_r <= 1'b0;
      any_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      stamp_r     <= stamp_nxt;
      armed_r     <= armed_nxt;
      cnt_r       <= cnt_nxt;
      due_found_r <= due_found_nxt;
      any_found_r <= any_found_nxt;
    end
    due_idx_r   <= due_idx_nxt;
    due_diff_r  <= due_diff_nxt;
    due_stamp_r <= due_stamp_nxt;
    any_diff_r  <= any_diff_nxt;
    any_stamp_r <= any_stamp_nxt;
  end

endmodule

@@ sv/dtq_res_fifo.sv @@
// Result queue between the back end and the result ports.
// Depends on dtq_pkg.
module dtq_res_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  dtq_pkg::res_push_t res_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output dtq_pkg::res_item_t head
);

  localparam int DEPTH = dtq_pkg::RESQ_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  dtq_pkg::res_item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          wr_ok, rd_ok;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign wr_ok = res_i.push && !full;
  assign rd_ok = pop && !empty;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!wr_ok && rd_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= res_i.item;
    end
  end

endmodule

@@ sv/dtq_checker.sv @@
// Port-level checker of the deadline timer queue and its bind statement.
// Depends on dtq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_kind,
  input logic [3:0]  out_timer_id_res,
  input logic [31:0] out_remaining,
  input logic        out_flag,
  input logic        out_last
);

  logic shown, last_ok, plain_kind, fields_clear;

  assign shown        = !out_empty;
  assign last_ok      = out_last == (out_kind != dtq_pkg::KIND_EXPIRED);
  assign plain_kind   = (out_kind == dtq_pkg::KIND_SET) || (out_kind == dtq_pkg::KIND_EXPIRED);
  assign fields_clear = !out_flag && (out_remaining == 32'd0);

  `DTQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty, "queue not empty after reset")
  `DTQ_ASSERT(a_kind_range, clk, rst_n, shown |-> out_kind <= dtq_pkg::KIND_FIRE, "bad kind")
  `DTQ_ASSERT(a_last_kind, clk, rst_n, shown |-> last_ok, "last mismatch")
  `DTQ_ASSERT(a_set_clean, clk, rst_n, (shown && plain_kind) |-> fields_clear, "stray field")
  `DTQ_ASSERT(a_hold, clk, rst_n, (shown && !out_pop) |=> (shown && $stable(out_kind) && $stable(out_timer_id_res)), "result changed")

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (.*);
